// ===== rtl/core/sacl_pkg.sv =====
// Shared types, constants and helpers for the set-associative LRU cache model.
package sacl_pkg;

	// Address and tag width
	localparam int ADDR_W = 64;
	localparam int TAG_W = 64;

	// Recency rank per line, 0 is most recent
	localparam int AGE_W = 3;
	localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

	// Running totals
	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Default geometry limits
	localparam int DEF_MAX_SET_BITS = 8;
	localparam int DEF_MAX_WAYS = 8;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SET_BITS_W = 4;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_CFG_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS       = 2'd2
	} cfg_idx_t;

	// Access modes; the unused code acts as a load
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_STORE  = 2'd1,
		MODE_MODIFY = 2'd2
	} mode_t;

	// Control sequencer
	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_LOOKUP = 1'b1
	} state_t;

	// Outcome of one set lookup
	typedef struct packed {
		logic hit;
		logic evicted;
	} lookup_flags_t;

	// Add a small increment to a total, holding at the top value
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] count,
		input logic [1:0] inc);
		logic [COUNT_W:0] sum;
		sum = {1'b0, count} + {{(COUNT_W-1){1'b0}}, inc};
		return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/sacl_row_mem.sv =====
// Set memory: one row per set holding valid bits, tags and ages of all ways.
module sacl_row_mem import sacl_pkg::*; #(
	parameter int SET_IDX_W = DEF_MAX_SET_BITS,
	parameter int WAYS = DEF_MAX_WAYS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [SET_IDX_W-1:0]            rd_addr,
	output logic [WAYS-1:0]                 rd_valid,
	output logic [WAYS-1:0][TAG_W-1:0]      rd_tag,
	output logic [WAYS-1:0][AGE_W-1:0]      rd_age,
	input  logic                            wr_en,
	input  logic [SET_IDX_W-1:0]            wr_addr,
	input  logic [WAYS-1:0]                 wr_valid,
	input  logic [WAYS-1:0][TAG_W-1:0]      wr_tag,
	input  logic [WAYS-1:0][AGE_W-1:0]      wr_age
);

	localparam int SETS = 1 << SET_IDX_W;

	logic [WAYS-1:0]            valid_mem [SETS];
	logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];
	logic [WAYS-1:0][AGE_W-1:0] age_mem   [SETS];

	logic [SETS-1:0]            written_q;
	logic                       row_ok_q;
	logic [WAYS-1:0]            valid_q;
	logic [WAYS-1:0][TAG_W-1:0] tag_q;
	logic [WAYS-1:0][AGE_W-1:0] age_q;

	// Mark rows written since reset; an unwritten row reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			row_ok_q <= 1'b0;
		end else begin
			if (rd_en) begin
				row_ok_q <= written_q[rd_addr];
			end
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Write a whole row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			tag_mem[wr_addr] <= wr_tag;
			age_mem[wr_addr] <= wr_age;
		end
	end

	// Registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			valid_q <= valid_mem[rd_addr];
			tag_q <= tag_mem[rd_addr];
			age_q <= age_mem[rd_addr];
		end
	end

	assign rd_valid = row_ok_q ? valid_q : '0;
	assign rd_age = row_ok_q ? age_q : '0;
	assign rd_tag = tag_q;

endmodule

// ===== rtl/core/sacl_lookup.sv =====
// Way compare, victim choice and LRU update for one set row.
module sacl_lookup import sacl_pkg::*; #(
	parameter int WAYS = DEF_MAX_WAYS,
	parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
	parameter int WAY_CNT_W = $clog2(WAYS + 1)
) (
	input  logic [WAY_CNT_W-1:0]            n_ways,
	input  logic [TAG_W-1:0]                tag,
	input  logic [WAYS-1:0]                 row_valid,
	input  logic [WAYS-1:0][TAG_W-1:0]      row_tag,
	input  logic [WAYS-1:0][AGE_W-1:0]      row_age,
	output lookup_flags_t                   flags,
	output logic [WAYS-1:0]                 new_valid,
	output logic [WAYS-1:0][TAG_W-1:0]      new_tag,
	output logic [WAYS-1:0][AGE_W-1:0]      new_age
);

	logic [WAYS-1:0]  active;
	logic [WAYS-1:0]  hit_vec;
	logic [WAYS-1:0]  free_vec;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] victim;
	logic [AGE_W-1:0] best_age;
	logic [WAY_W-1:0] sel_way;
	logic             was_valid;
	logic [AGE_W:0]   ref_age;

	// Compare every active way against the tag
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			active[i] = WAY_CNT_W'(i) < n_ways;
			hit_vec[i] = active[i] & row_valid[i] & (row_tag[i] == tag);
			free_vec[i] = active[i] & ~row_valid[i];
		end
	end

	// Pick the lowest hit way and the lowest free way
	always_comb begin
		hit_way = '0;
		free_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = WAY_W'(i);
			end
			if (free_vec[i]) begin
				free_way = WAY_W'(i);
			end
		end
	end

	// Find the lowest active way with the largest age
	always_comb begin
		victim = '0;
		best_age = row_age[0];
		for (int i = 1; i < WAYS; i++) begin
			if (active[i] && (row_age[i] > best_age)) begin
				victim = WAY_W'(i);
				best_age = row_age[i];
			end
		end
	end

	// Choose the way to touch
	always_comb begin
		flags = '0;
		if (|hit_vec) begin
			sel_way = hit_way;
			was_valid = 1'b1;
			flags.hit = 1'b1;
		end else if (|free_vec) begin
			sel_way = free_way;
			was_valid = 1'b0;
		end else begin
			sel_way = victim;
			was_valid = 1'b1;
			flags.evicted = 1'b1;
		end
		ref_age = was_valid ? {1'b0, row_age[sel_way]} : (AGE_W + 1)'(1 << AGE_W);
	end

	// Age the more recent lines, make the touched way most recent
	always_comb begin
		new_valid = row_valid;
		new_tag = row_tag;
		new_age = row_age;
		for (int i = 0; i < WAYS; i++) begin
			if (active[i] && (WAY_W'(i) != sel_way) && row_valid[i] &&
				({1'b0, row_age[i]} < ref_age) && (row_age[i] < AGE_MAX)) begin
				new_age[i] = row_age[i] + AGE_W'(1);
			end
		end
		new_age[sel_way] = '0;
		new_valid[sel_way] = 1'b1;
		new_tag[sel_way] = tag;
	end

endmodule

// ===== rtl/core/set_assoc_cache_lru_sim_core.sv =====
// Top level of the set-associative LRU cache hit/miss model.
//
// Input channel (in_valid/in_ready) takes one word per access: mode and a
// 64-bit byte address. The set index and tag follow from set_bits and
// block_bits. Output channel (out_valid/out_ready) returns one word per
// access: hit, miss, evicted and the running saturating totals.
// An access reads the set row from the set memory at the accept edge; once
// the output register is free, the updated row is written back and the
// output register is loaded at the same edge. A new word is accepted only
// after that write-back, as the sequencer holds off the next row read until
// the updated row is written back, so one access never overlaps the next. A
// modify counts its second, always-hitting access in the same pass. The cfg
// port (cfg_we, cfg_index, cfg_data) writes set_bits, block_bits and ways;
// write it only while the block is idle.
// Reset empties every set at once through per-row written flags, clears the
// totals and sets one way. When the receiver stalls, the finished word holds
// in the output register and the next access waits in its lookup stage.
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [ADDR_W-1:0]     address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic                  miss,
	output logic                  evicted,
	output logic [COUNT_W-1:0]    total_hits,
	output logic [COUNT_W-1:0]    total_misses,
	output logic [COUNT_W-1:0]    total_evictions
);

	localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
	localparam int SB_W = 5;
	localparam int SHIFT_W = 7;

	state_t state_q, state_d;

	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_CFG_W-1:0]   ways_q;

	logic [SET_IDX_W-1:0] set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic                 modify_s1;

	logic [COUNT_W-1:0] hits_q, misses_q, evicts_q;
	logic               out_valid_q;
	logic               hit_q, evicted_q;

	logic                 accept;
	logic                 finish;
	logic [SB_W-1:0]      sb;
	logic [SHIFT_W-1:0]   tag_shift;
	logic [ADDR_W-1:0]    set_mask;
	logic [ADDR_W-1:0]    offset_dropped;
	logic [SET_IDX_W-1:0] set_idx;
	logic [TAG_W-1:0]     tag_calc;
	logic [WAY_CNT_W-1:0] n_ways;

	logic [MAX_WAYS-1:0]             rd_valid, wr_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag, wr_tag;
	logic [MAX_WAYS-1:0][AGE_W-1:0]  rd_age, wr_age;
	lookup_flags_t                   flags;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= '0;
			block_bits_q <= '0;
			ways_q <= WAYS_CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q <= cfg_data[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLOCK_BITS_W-1:0];
				CFG_WAYS:       ways_q <= cfg_data[WAYS_CFG_W-1:0];
				default:        ;
			endcase
		end
	end

	// Clamp set bits and ways to the built geometry
	always_comb begin
		sb = ({1'b0, set_bits_q} > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
			: {1'b0, set_bits_q};
		if (ways_q == '0) begin
			n_ways = WAY_CNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			n_ways = WAY_CNT_W'(MAX_WAYS);
		end else begin
			n_ways = WAY_CNT_W'(ways_q);
		end
	end

	// Split the address into set index and tag
	always_comb begin
		tag_shift = SHIFT_W'(sb) + SHIFT_W'(block_bits_q);
		set_mask = (ADDR_W'(1) << sb) - ADDR_W'(1);
		offset_dropped = (address >> block_bits_q) & set_mask;
		set_idx = offset_dropped[SET_IDX_W-1:0];
		tag_calc = (tag_shift >= SHIFT_W'(ADDR_W)) ? '0 : (address >> tag_shift[5:0]);
	end

	assign accept = in_valid && in_ready;
	assign finish = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_LOOKUP;
			ST_LOOKUP: if (finish) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	// Capture the access for the lookup stage
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_idx;
			tag_s1 <= tag_calc;
			modify_s1 <= (mode == MODE_MODIFY);
		end
	end

	sacl_row_mem #(
		.SET_IDX_W(SET_IDX_W),
		.WAYS(MAX_WAYS)
	) u_row_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(set_idx),
		.rd_valid(rd_valid),
		.rd_tag(rd_tag),
		.rd_age(rd_age),
		.wr_en(finish),
		.wr_addr(set_s1),
		.wr_valid(wr_valid),
		.wr_tag(wr_tag),
		.wr_age(wr_age)
	);

	sacl_lookup #(
		.WAYS(MAX_WAYS),
		.WAY_W(WAY_W),
		.WAY_CNT_W(WAY_CNT_W)
	) u_lookup (
		.n_ways(n_ways),
		.tag(tag_s1),
		.row_valid(rd_valid),
		.row_tag(rd_tag),
		.row_age(rd_age),
		.flags(flags),
		.new_valid(wr_valid),
		.new_tag(wr_tag),
		.new_age(wr_age)
	);

	// Advance the totals and the output word at write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			misses_q <= '0;
			evicts_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				hits_q <= sat_add(hits_q, {1'b0, flags.hit} + {1'b0, modify_s1});
				misses_q <= sat_add(misses_q, {1'b0, !flags.hit});
				evicts_q <= sat_add(evicts_q, {1'b0, flags.evicted});
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the outcome flags with the word
	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q <= flags.hit;
			evicted_q <= flags.evicted;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign miss = !hit_q;
	assign evicted = evicted_q;
	assign total_hits = hits_q;
	assign total_misses = misses_q;
	assign total_evictions = evicts_q;

endmodule
